/* hw/rtl/dph_pkg.sv */
// Shared types and codes for the dual projection histogram.
`timescale 1ns / 1ps

package dph_pkg;

	localparam int POS_W   = 32;
	localparam int OUT_W   = 32;
	localparam int CMD_W   = 2;
	localparam int RC_IN_W = 8;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam int PROD_W  = 24;  // product bits kept above the Q16.16 x Q8.24 point

	localparam logic [CMD_W-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] REG_RANGE_LOW  = 2'd0;
	localparam logic [1:0] REG_RANGE_HIGH = 2'd1;
	localparam logic [1:0] REG_BIN_SCALE  = 2'd2;

	localparam logic signed [POS_W-1:0] RANGE_LOW_RST  = -32'sd8296858;
	localparam logic signed [POS_W-1:0] RANGE_HIGH_RST = 32'sd8296858;
	localparam logic [POS_W-1:0]        BIN_SCALE_RST  = 32'd13981013;

	typedef struct packed {
		logic capture;   // latch the accepted request
		logic prep;      // edge compares and offsets
		logic mul;       // offset times scale
		logic bin;       // clamp to bin numbers
		logic addr_rec;  // cell addresses from the bins
		logic addr_rd;   // cell address from row and column
		logic mem_rd;    // read both stores
		logic mem_wr;    // write back incremented counts
		logic clr_wr;    // zero one cell of each store
		logic out_load;  // load the result register
	} dph_ctl_t;

	typedef struct packed {
		logic clr_last;
	} dph_sts_t;

endpackage

/* hw/rtl/dual_projection_histogram.sv */
// Top level: register port, sequencer and datapath of the projection histogram.
//
//  channel  direction  handshake                  payload
//  in       request    in_valid / in_stall        cmd, pos_x, pos_y, pos_z,
//                                                 read_view, read_row, read_col
//  out      result     out_valid / out_stall      bin_count
//  cfg      write/read psel penable pwrite pready paddr, pwdata, prdata
//
// A record request steps through offset, multiply, clamp, address, read and
// write back; a read through address, read and result load, plus any wait for
// the result register; a clear runs the sweep, which zeroes one cell of each
// store a cycle. After reset the same sweep clears all NUM_BINS*NUM_BINS cells
// (44521 by default) with in_stall high; register writes are taken throughout.
// A waiting result does not block: the next request is accepted under out_stall.
`timescale 1ns / 1ps

module dual_projection_histogram
	import dph_pkg::*;
#(
	parameter int NUM_BINS    = 211,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CMD_W-1:0]        cmd,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic                    read_view,
	input  logic [RC_IN_W-1:0]      read_row,
	input  logic [RC_IN_W-1:0]      read_col,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [OUT_W-1:0]        bin_count,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [PDATA_W-1:0]      pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

	logic signed [POS_W-1:0] range_low_q, range_high_q;
	logic [POS_W-1:0]        bin_scale_q;
	logic                    cfg_wr;
	dph_ctl_t                ctl;
	dph_sts_t                sts;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= RANGE_LOW_RST;
			range_high_q <= RANGE_HIGH_RST;
			bin_scale_q  <= BIN_SCALE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_RANGE_LOW:  range_low_q  <= pwdata;
				REG_RANGE_HIGH: range_high_q <= pwdata;
				REG_BIN_SCALE:  bin_scale_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RANGE_LOW:  prdata = range_low_q;
			REG_RANGE_HIGH: prdata = range_high_q;
			REG_BIN_SCALE:  prdata = bin_scale_q;
			default:        prdata = '0;
		endcase
	end

	dph_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	dph_datapath #(
		.NUM_BINS    (NUM_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.range_low  (range_low_q),
		.range_high (range_high_q),
		.bin_scale  (bin_scale_q),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.read_view  (read_view),
		.read_row   (read_row),
		.read_col   (read_col),
		.bin_count  (bin_count)
	);

endmodule

/* hw/rtl/dph_ctrl.sv */
// Sequencer for record, read and clear requests and the clearing sweep.
`timescale 1ns / 1ps

module dph_ctrl
	import dph_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] cmd,
	output logic             out_valid,
	input  logic             out_stall,
	output dph_ctl_t         ctl,
	input  dph_sts_t         sts
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_MUL   = 4'd2;
	localparam logic [3:0] ST_BIN   = 4'd3;
	localparam logic [3:0] ST_ADDR  = 4'd4;
	localparam logic [3:0] ST_RD    = 4'd5;
	localparam logic [3:0] ST_WR    = 4'd6;
	localparam logic [3:0] ST_RPREP = 4'd7;
	localparam logic [3:0] ST_RRD   = 4'd8;
	localparam logic [3:0] ST_ROUT  = 4'd9;
	localparam logic [3:0] ST_CLR   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.capture = 1'b1;
					unique case (cmd)
						CMD_RECORD: state_d = ST_PREP;
						CMD_READ:   state_d = ST_RPREP;
						CMD_CLEAR:  state_d = ST_CLR;
						default:    state_d = ST_IDLE;
					endcase
				end
			end
			ST_PREP: begin
				ctl.prep = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul = 1'b1;
				state_d = ST_BIN;
			end
			ST_BIN: begin
				ctl.bin = 1'b1;
				state_d = ST_ADDR;
			end
			ST_ADDR: begin
				ctl.addr_rec = 1'b1;
				state_d      = ST_RD;
			end
			ST_RD: begin
				ctl.mem_rd = 1'b1;
				state_d    = ST_WR;
			end
			ST_WR: begin
				ctl.mem_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RPREP: begin
				ctl.addr_rd = 1'b1;
				state_d     = ST_RRD;
			end
			ST_RRD: begin
				ctl.mem_rd = 1'b1;
				state_d    = ST_ROUT;
			end
			ST_ROUT: begin
				// wait here until the result register can take the count
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_CLR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/dph_datapath.sv */
// Binning arithmetic, the two count stores and the result register.
`timescale 1ns / 1ps

module dph_datapath
	import dph_pkg::*;
#(
	parameter int NUM_BINS    = 211,
	parameter int COUNT_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dph_ctl_t                  ctl,
	output dph_sts_t                  sts,
	input  logic signed [POS_W-1:0]   range_low,
	input  logic signed [POS_W-1:0]   range_high,
	input  logic [POS_W-1:0]          bin_scale,
	input  logic signed [POS_W-1:0]   pos_x,
	input  logic signed [POS_W-1:0]   pos_y,
	input  logic signed [POS_W-1:0]   pos_z,
	input  logic                      read_view,
	input  logic [RC_IN_W-1:0]        read_row,
	input  logic [RC_IN_W-1:0]        read_col,
	output logic [OUT_W-1:0]          bin_count
);

	localparam int CELLS  = NUM_BINS * NUM_BINS;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int BIN_W  = $clog2(NUM_BINS);
	localparam int RC_W   = ((BIN_W > RC_IN_W) ? BIN_W : RC_IN_W) + 1;
	localparam int WIDE_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

	// coordinate order: x, y, z
	logic signed [POS_W-1:0]  pos_q   [3];
	logic                     ge_q    [3];
	logic                     lt_q    [3];
	logic [POS_W-1:0]         off_q   [3];
	logic [PROD_W-1:0]        prod_q  [3];
	logic [BIN_W-1:0]         bin_q   [3];
	logic                     view_q;
	logic [RC_IN_W-1:0]       row_q, col_q;
	logic                     rd_ok_q;
	logic [ADDR_W-1:0]        addr_xz_q, addr_yz_q;
	logic [ADDR_W-1:0]        clr_ptr_q;
	logic [COUNT_WIDTH-1:0]   xz_rd_q, yz_rd_q;
	logic [OUT_W-1:0]         count_q;

	logic [COUNT_WIDTH-1:0]   xz_mem [CELLS];
	logic [COUNT_WIDTH-1:0]   yz_mem [CELLS];

	logic [ADDR_W-1:0]        wr_addr_xz, wr_addr_yz;
	logic [COUNT_WIDTH-1:0]   wr_xz, wr_yz;
	logic                     wr_en;
	logic [COUNT_WIDTH-1:0]   sel_cnt;
	logic [WIDE_W-1:0]        sel_wide;
	logic [RC_W-1:0]          row_ext, col_ext;
	logic [ADDR_W-1:0]        row_base;
	logic [2*POS_W-1:0]       prod_full [3];

	assign sts.clr_last = (clr_ptr_q == ADDR_W'(CELLS - 1));
	assign row_ext      = RC_W'(row_q);
	assign col_ext      = RC_W'(col_q);
	assign row_base     = ADDR_W'(bin_q[2]) * ADDR_W'(NUM_BINS);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_full[i] = {{POS_W{1'b0}}, off_q[i]} * {{POS_W{1'b0}}, bin_scale};
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
			view_q   <= read_view;
			row_q    <= read_row;
			col_q    <= read_col;
		end
		for (int i = 0; i < 3; i++) begin
			if (ctl.prep) begin
				ge_q[i]  <= (pos_q[i] >= range_high);
				lt_q[i]  <= (pos_q[i] < range_low);
				// wraps correctly to 0..2^32-1 whenever pos >= range_low
				off_q[i] <= pos_q[i] - range_low;
			end
			if (ctl.mul) begin
				prod_q[i] <= prod_full[i][2*POS_W-1 -: PROD_W];
			end
			if (ctl.bin) begin
				if (ge_q[i]) begin
					bin_q[i] <= BIN_W'(NUM_BINS - 1);
				end else if (lt_q[i]) begin
					bin_q[i] <= '0;
				end else if (prod_q[i] > PROD_W'(NUM_BINS - 1)) begin
					bin_q[i] <= BIN_W'(NUM_BINS - 1);
				end else begin
					bin_q[i] <= prod_q[i][BIN_W-1:0];
				end
			end
		end
		if (ctl.addr_rec) begin
			addr_xz_q <= row_base + ADDR_W'(bin_q[0]);
			addr_yz_q <= row_base + ADDR_W'(bin_q[1]);
		end else if (ctl.addr_rd) begin
			addr_xz_q <= ADDR_W'(row_q) * ADDR_W'(NUM_BINS) + ADDR_W'(col_q);
			addr_yz_q <= ADDR_W'(row_q) * ADDR_W'(NUM_BINS) + ADDR_W'(col_q);
			rd_ok_q   <= (row_ext < RC_W'(NUM_BINS)) && (col_ext < RC_W'(NUM_BINS));
		end
		if (ctl.out_load) begin
			count_q <= (sel_wide > WIDE_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}}
				: sel_wide[OUT_W-1:0];
		end
	end

	// clearing sweep pointer, back at zero after every sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_ptr_q <= '0;
		end else if (ctl.clr_wr) begin
			clr_ptr_q <= sts.clr_last ? '0 : clr_ptr_q + 1'b1;
		end
	end

	always_comb begin
		wr_en      = ctl.mem_wr || ctl.clr_wr;
		wr_addr_xz = ctl.clr_wr ? clr_ptr_q : addr_xz_q;
		wr_addr_yz = ctl.clr_wr ? clr_ptr_q : addr_yz_q;
		if (ctl.clr_wr) begin
			wr_xz = '0;
			wr_yz = '0;
		end else begin
			wr_xz = (&xz_rd_q) ? xz_rd_q : xz_rd_q + 1'b1;
			wr_yz = (&yz_rd_q) ? yz_rd_q : yz_rd_q + 1'b1;
		end
		if (!rd_ok_q) begin
			sel_cnt = '0;
		end else begin
			sel_cnt = view_q ? yz_rd_q : xz_rd_q;
		end
		sel_wide = WIDE_W'(sel_cnt);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			xz_mem[wr_addr_xz] <= wr_xz;
			yz_mem[wr_addr_yz] <= wr_yz;
		end
		if (ctl.mem_rd) begin
			xz_rd_q <= xz_mem[addr_xz_q];
			yz_rd_q <= yz_mem[addr_yz_q];
		end
	end

	assign bin_count = count_q;

endmodule

/* sim/tb.sv */
// Testbench for the dual projection histogram: counts are predicted here and every read is checked.
`timescale 1ns / 1ps

module tb;
	import dph_pkg::*;

	localparam int NUM_BINS     = 211;
	localparam int CELLS        = NUM_BINS * NUM_BINS;
	localparam int SETTLE       = 16;
	localparam int CYCLE_LIMIT  = 2_500_000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASES       = 12;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		logic [CMD_W-1:0]        op;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic                    view;
		logic [RC_IN_W-1:0]      row;
		logic [RC_IN_W-1:0]      col;
	} hist_req_t;

	typedef struct {
		logic               view;
		logic [RC_IN_W-1:0] row;
		logic [RC_IN_W-1:0] col;
	} slot_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [CMD_W-1:0]        cmd;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic                    read_view;
	logic [RC_IN_W-1:0]      read_row;
	logic [RC_IN_W-1:0]      read_col;
	logic                    out_valid;
	logic                    out_stall;
	logic [OUT_W-1:0]        bin_count;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [PADDR_W-1:0]      paddr;
	logic [PDATA_W-1:0]      pwdata;
	logic [PDATA_W-1:0]      prdata;
	logic                    pready;

	// predicted stores and binning settings
	bit [31:0]          xz_model [CELLS];
	bit [31:0]          yz_model [CELLS];
	logic signed [31:0] cfg_lo;
	logic signed [31:0] cfg_hi;
	logic [31:0]        cfg_scale;
	longint             clus_ctr;

	logic [31:0] count_expect_q [$];
	slot_t       hit_q [$];
	int          err_cnt;
	int          items_sent;
	int unsigned cyc;
	bit          quiet;

	dual_projection_histogram u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc >= CYCLE_LIMIT) begin
			$display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(30, 80);
	endfunction

	function automatic int unsigned bin_of_pos(logic signed [31:0] v);
		logic [63:0] d;
		logic [63:0] b;
		if (v >= cfg_hi)
			return NUM_BINS - 1;
		if (v < cfg_lo)
			return 0;
		d = 64'(longint'(v) - longint'(cfg_lo));
		b = (d * {32'd0, cfg_scale}) >> 40;
		if (b > NUM_BINS - 1)
			b = NUM_BINS - 1;
		return int'(b);
	endfunction

	function automatic void note_hit(slot_t s);
		hit_q.insert(hit_q.size(), s);
	endfunction

	function automatic void expect_count(logic [31:0] c);
		count_expect_q.insert(count_expect_q.size(), c);
	endfunction

	// update the predicted stores for one accepted request
	function automatic void apply_request(hist_req_t r);
		int unsigned bx, by, bz, a, i;
		case (r.op)
			CMD_RECORD: begin
				bx = bin_of_pos(r.x);
				by = bin_of_pos(r.y);
				bz = bin_of_pos(r.z);
				a = bz * NUM_BINS + bx;
				if (xz_model[a] != '1)
					xz_model[a]++;
				a = bz * NUM_BINS + by;
				if (yz_model[a] != '1)
					yz_model[a]++;
				note_hit('{view: 1'b0, row: RC_IN_W'(bz), col: RC_IN_W'(bx)});
				note_hit('{view: 1'b1, row: RC_IN_W'(bz), col: RC_IN_W'(by)});
				while (hit_q.size() > 48)
					void'(hit_q.pop_front());
			end
			CMD_READ: begin
				if (r.row < NUM_BINS && r.col < NUM_BINS) begin
					a = r.row * NUM_BINS + r.col;
					expect_count(r.view ? yz_model[a] : xz_model[a]);
				end else begin
					expect_count('0);
				end
			end
			CMD_CLEAR: begin
				for (i = 0; i < CELLS; i++) begin
					xz_model[i] = '0;
					yz_model[i] = '0;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic hist_req_t rand_req();
		hist_req_t r;
		r.op = CMD_RECORD;
		r.x = $urandom;
		r.y = $urandom;
		r.z = $urandom;
		r.view = 1'($urandom);
		r.row = RC_IN_W'($urandom);
		r.col = RC_IN_W'($urandom);
		return r;
	endfunction

	function automatic hist_req_t mk_record(logic signed [31:0] x, y, z);
		hist_req_t r;
		r = rand_req();
		r.op = CMD_RECORD;
		r.x = x;
		r.y = y;
		r.z = z;
		return r;
	endfunction

	function automatic hist_req_t mk_read(logic view, logic [RC_IN_W-1:0] row, col);
		hist_req_t r;
		r = rand_req();
		r.op = CMD_READ;
		r.view = view;
		r.row = row;
		r.col = col;
		return r;
	endfunction

	function automatic hist_req_t mk_op(logic [CMD_W-1:0] op);
		hist_req_t r;
		r = rand_req();
		r.op = op;
		return r;
	endfunction

	// mostly inside the range, with edges, a tight cluster and raw 32-bit values mixed in
	function automatic logic signed [31:0] pick_pos();
		longint v, span;
		int r;
		span = longint'(cfg_hi) - longint'(cfg_lo);
		r = $urandom_range(0, 99);
		if (span <= 0 || r < 20) begin
			v = longint'($signed($urandom));
		end else if (r < 35) begin
			case ($urandom_range(0, 3))
				0: v = cfg_hi;
				1: v = longint'(cfg_hi) - 1;
				2: v = cfg_lo;
				default: v = longint'(cfg_lo) - 1;
			endcase
		end else if (r < 65) begin
			v = clus_ctr + longint'($urandom_range(0, 32'(span / 64 + 1)));
		end else begin
			v = longint'(cfg_lo) + longint'({$urandom, $urandom} % span);
		end
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	task automatic send_req(hist_req_t r);
		int n;
		@(negedge clk);
		in_valid = 1'b1;
		cmd = r.op;
		pos_x = r.x;
		pos_y = r.y;
		pos_z = r.z;
		read_view = r.view;
		read_row = r.row;
		read_col = r.col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_request(r);
		if (r.op != CMD_UNUSED)
			items_sent++;
		if (!quiet && $urandom_range(0, 1) == 1) begin
			n = pick_gap();
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1)
				@(negedge clk);
		end
	endtask

	task automatic idle_in();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// drain: all results back, then room for a record still in flight or a clear sweep
	task automatic wait_results_done();
		idle_in();
		while (count_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
		while (in_stall)
			@(posedge clk);
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic set_binning(logic signed [31:0] lo, hi, logic [31:0] scale);
		logic [1:0]  idx_list [3];
		logic [31:0] vals [3];
		logic [31:0] rd;
		longint      span;
		int          i;
		idx_list = '{REG_RANGE_LOW, REG_RANGE_HIGH, REG_BIN_SCALE};
		vals = '{lo, hi, scale};
		wait_results_done();
		for (i = 0; i < 3; i++)
			apb_xfer(1'b1, idx_list[i], vals[i], rd);
		cfg_lo = lo;
		cfg_hi = hi;
		cfg_scale = scale;
		for (i = 0; i < 3; i++) begin
			apb_xfer(1'b0, idx_list[i], '0, rd);
			if (rd !== vals[i]) begin
				$display("%0t: register %0d readback, expected %h actual %h",
					$time, idx_list[i], vals[i], rd);
				err_cnt++;
			end
		end
		span = longint'(hi) - longint'(lo);
		clus_ctr = (span > 0) ? longint'(lo) + longint'({$urandom, $urandom} % span) : lo;
	endtask

	task automatic read_back(logic signed [31:0] x, y, z);
		int unsigned bz;
		bz = bin_of_pos(z);
		send_req(mk_read(1'b0, RC_IN_W'(bz), RC_IN_W'(bin_of_pos(x))));
		send_req(mk_read(1'b1, RC_IN_W'(bz), RC_IN_W'(bin_of_pos(y))));
	endtask

	// reset settings: exact edges, extremes of the position, reads outside the store, an unused command
	task automatic test_edge_binning();
		send_req(mk_record(cfg_hi, cfg_lo, cfg_lo - 1));
		send_req(mk_record(32'sh7FFF_FFFF, 32'sh8000_0000, cfg_hi - 1));
		read_back(cfg_hi, cfg_lo, cfg_lo - 1);
		read_back(32'sh7FFF_FFFF, 32'sh8000_0000, cfg_hi - 1);
		send_req(mk_read(1'b0, RC_IN_W'(NUM_BINS), '0));
		send_req(mk_read(1'b1, '0, 8'hFF));
		send_req(mk_read(1'b1, 8'hFF, 8'hFF));
		send_req(mk_op(CMD_UNUSED));
	endtask

	task automatic test_scale_extremes();
		set_binning(32'sh8000_0000, 32'sh7FFF_FFFF, 32'd54016);
		send_req(mk_record(0, 32'sh8000_0000, 32'sh7FFF_FFFE));
		read_back(0, 32'sh8000_0000, 32'sh7FFF_FFFE);
		// scale far above the range: computed bins run past the last one
		set_binning(-32'sd65536, 32'sd65536, 32'hFFFF_FFFF);
		send_req(mk_record(0, -1, 1000));
		read_back(0, -1, 1000);
		set_binning(-32'sd65536, 32'sd65536, 32'd0);
		send_req(mk_record(65535, 65536, -65536));
		read_back(65535, 65536, -65536);
	endtask

	task automatic test_inverted_range();
		set_binning(32'sd1000, -32'sd1000, BIN_SCALE_RST);
		send_req(mk_record(0, -2000, 2000));
		read_back(0, -2000, 2000);
		set_binning(32'sd0, 32'sd0, BIN_SCALE_RST);
		send_req(mk_record(0, -1, 1));
		read_back(0, -1, 1);
	endtask

	task automatic test_clear();
		send_req(mk_op(CMD_CLEAR));
		read_back(0, -1, 1);
	endtask

	task automatic test_random_traffic();
		int     phase, r, quota, clears_left;
		longint lo_l, w;
		slot_t  s;
		clears_left = 2;
		for (phase = 0; phase < PHASES; phase++) begin
			if (phase % 4 == 3) begin
				set_binning($urandom, $urandom, $urandom);
			end else begin
				w = longint'($urandom) >> $urandom_range(0, 15);
				if (w < 65536)
					w = 65536;
				lo_l = longint'($urandom_range(0, 32'(64'd4294967295 - w))) - 64'sd2147483648;
				set_binning(32'(lo_l), 32'(lo_l + w), 32'((64'(NUM_BINS) << 40) / w));
			end
			quiet = ($urandom_range(0, 3) == 0);
			quota = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < quota) begin
				r = $urandom_range(0, 99);
				if (r < 3) begin
					send_req(mk_op(CMD_UNUSED));
				end else if (r < 60) begin
					send_req(mk_record(pick_pos(), pick_pos(), pick_pos()));
				end else begin
					r = $urandom_range(0, 99);
					if (r < 40 && hit_q.size() != 0)
						s = hit_q[$urandom_range(0, hit_q.size() - 1)];
					else if (r < 75)
						s = '{view: 1'($urandom), row: RC_IN_W'($urandom_range(0, NUM_BINS - 1)),
							col: RC_IN_W'($urandom_range(0, NUM_BINS - 1))};
					else
						s = '{view: 1'($urandom), row: RC_IN_W'($urandom),
							col: RC_IN_W'($urandom)};
					send_req(mk_read(s.view, s.row, s.col));
				end
				if ($urandom_range(0, 99) == 0)
					quiet = !quiet;
				// sender holds off until the result side is empty
				if (phase % 3 == 1 && items_sent == quota - 60)
					wait_results_done();
				if (clears_left != 0 && phase % 5 == 2 && items_sent == quota - 40) begin
					send_req(mk_op(CMD_CLEAR));
					clears_left--;
				end
			end
		end
	endtask

	initial begin : result_stall_gen
		int left;
		left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (left == 0 && !quiet && $urandom_range(0, 3) == 0)
				left = pick_gap();
			out_stall = (left != 0);
			if (left != 0)
				left--;
		end
	end

	always @(posedge clk) begin : result_check
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (count_expect_q.size() == 0) begin
				$display("%0t: result with no read pending, expected none actual %0d",
					$time, bin_count);
				err_cnt++;
			end else begin
				want = count_expect_q.pop_front();
				if (bin_count !== want) begin
					$display("%0t: bin_count mismatch, expected %0d actual %0d",
						$time, want, bin_count);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_RECORD;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		read_view = 1'b0;
		read_row = '0;
		read_col = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_lo = RANGE_LOW_RST;
		cfg_hi = RANGE_HIGH_RST;
		cfg_scale = BIN_SCALE_RST;
		clus_ctr = 0;
		repeat (11)
			@(negedge clk);
		arst_n = 1'b1;

		test_edge_binning();
		test_scale_extremes();
		test_inverted_range();
		test_clear();
		test_random_traffic();
		wait_results_done();

		if (err_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
